// ===== hw/rtl/drl_pkg.sv =====
// Shared types and codes for the dense rank lookup block.
package drl_pkg;

   localparam int RANK_BITS   = 11;
   localparam int STATUS_BITS = 3;
   localparam int CMD_BITS    = 2;
   localparam int FIELD_BITS  = 32;

   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;

   localparam logic [STATUS_BITS-1:0] STATUS_RANKED    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_CLEARED   = 3'd4;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [FIELD_BITS-1:0] score;
   } req_word_type;

   typedef struct packed {
      logic [RANK_BITS-1:0]   rank;
      logic [STATUS_BITS-1:0] status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_PROBE,
      SEQ_SEARCH,
      SEQ_DECIDE,
      SEQ_SHIFT,
      SEQ_PLACE,
      SEQ_REPLY
   } seq_state_type;

endpackage

// ===== hw/rtl/drl_score_ram.sv =====
// Score table memory: one write port, one registered read port.
module drl_score_ram import drl_pkg::*; #(
   parameter int ENTRIES    = 1024,
   parameter int SCORE_BITS = 32,
   localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [SCORE_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [SCORE_BITS-1:0] rd_data
);

   logic [SCORE_BITS-1:0] mem_ff [ENTRIES];
   logic [SCORE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/drl_seq.sv =====
// Search and insert sequencer: binary search, shift-up insert, entry count.
module drl_seq import drl_pkg::*; #(
   parameter int ENTRIES    = 1024,
   parameter int SCORE_BITS = 32,
   localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CW        = $clog2(ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_take,
   input  logic [CMD_BITS-1:0]   req_cmd,
   input  logic [SCORE_BITS-1:0] req_key,
   output logic                  busy,
   output logic                  res_valid,
   input  logic                  res_take,
   output rsp_word_type          res_word,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [SCORE_BITS-1:0] wr_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [SCORE_BITS-1:0] rd_data
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   seq_state_type state_ff, state_in;

   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         mid_ff, mid_in;
   logic [CW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         dest_ff, dest_in;
   logic                  pend_ff, pend_in;
   logic                  eq_ff, eq_in;
   logic [CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic [SCORE_BITS-1:0] key_ff, key_in;
   rsp_word_type          res_ff, res_in;

   logic          is_insert;
   logic          go_right;
   logic [CW-1:0] lo_b, hi_b, mid_n, cur_dec;
   logic          more;
   logic          shift_rd;
   logic          dup;
   logic [CW:0]   rank_w;

   always_comb begin
      is_insert = (cmd_ff == CMD_INSERT);
      go_right  = is_insert ? (rd_data < key_ff) : (rd_data <= key_ff);
      if (state_ff == SEQ_SEARCH) begin
         lo_b = go_right ? mid_ff + CW'(1) : lo_ff;
         hi_b = go_right ? hi_ff : mid_ff;
      end else begin
         lo_b = lo_ff;
         hi_b = hi_ff;
      end
      mid_n    = lo_b + ((hi_b - lo_b) >> 1);
      more     = (lo_b < hi_b);
      cur_dec  = cur_ff - CW'(1);
      shift_rd = (cur_ff > lo_ff);
      dup      = eq_ff && (lo_ff < count_ff);
      rank_w   = {1'b0, count_ff} - {1'b0, lo_ff} + {{CW{1'b0}}, 1'b1};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               state_in = (req_cmd == CMD_CLEAR) ? SEQ_REPLY : SEQ_PROBE;
            end
         end
         SEQ_PROBE, SEQ_SEARCH: begin
            state_in = more ? SEQ_SEARCH : SEQ_DECIDE;
         end
         SEQ_DECIDE: begin
            if (!is_insert || dup || count_ff >= FULL_COUNT) begin
               state_in = SEQ_REPLY;
            end else begin
               state_in = SEQ_SHIFT;
            end
         end
         SEQ_SHIFT: begin
            if (!shift_rd) begin
               state_in = SEQ_PLACE;
            end
         end
         SEQ_PLACE: begin
            state_in = SEQ_REPLY;
         end
         SEQ_REPLY: begin
            if (res_take) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // datapath register updates
   always_comb begin
      count_in = count_ff;
      lo_in    = lo_b;
      hi_in    = hi_b;
      mid_in   = mid_n;
      cur_in   = cur_ff;
      dest_in  = dest_ff;
      pend_in  = 1'b0;
      eq_in    = eq_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            cmd_in = req_cmd;
            key_in = req_key;
            lo_in  = '0;
            hi_in  = count_ff;
            eq_in  = 1'b0;
            if (req_take && req_cmd == CMD_CLEAR) begin
               count_in = '0;
               res_in   = '{rank: '0, status: STATUS_CLEARED};
            end
         end
         SEQ_PROBE: begin
         end
         SEQ_SEARCH: begin
            if (!go_right) begin
               eq_in = (rd_data == key_ff);
            end
         end
         SEQ_DECIDE: begin
            cur_in = count_ff;
            if (!is_insert) begin
               res_in = '{rank: RANK_BITS'(rank_w), status: STATUS_RANKED};
            end else if (dup) begin
               res_in = '{rank: '0, status: STATUS_DUPLICATE};
            end else if (count_ff >= FULL_COUNT) begin
               res_in = '{rank: '0, status: STATUS_FULL};
            end
         end
         SEQ_SHIFT: begin
            lo_in = lo_ff;
            hi_in = hi_ff;
            if (shift_rd) begin
               cur_in  = cur_dec;
               dest_in = cur_ff;
               pend_in = 1'b1;
            end
         end
         SEQ_PLACE: begin
            count_in = count_ff + CW'(1);
            res_in   = '{rank: '0, status: STATUS_INSERTED};
         end
         SEQ_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // memory controls and handshake outputs
   always_comb begin
      busy      = (state_ff != SEQ_IDLE);
      res_valid = (state_ff == SEQ_REPLY);
      res_word  = res_ff;
      rd_en     = 1'b0;
      rd_addr   = mid_n[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = dest_ff[AW-1:0];
      wr_data   = rd_data;
      unique case (state_ff)
         SEQ_PROBE, SEQ_SEARCH: begin
            rd_en = more;
         end
         SEQ_SHIFT: begin
            rd_en   = shift_rd;
            rd_addr = cur_dec[AW-1:0];
            wr_en   = pend_ff;
         end
         SEQ_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[AW-1:0];
            wr_data = key_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      cur_ff  <= cur_in;
      dest_ff <= dest_in;
      eq_ff   <= eq_in;
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      res_ff  <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({1'b0, rd_addr} < {1'b0, count_ff}))
      else $error("read of an entry beyond the count");

   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SHIFT && wr_en) |-> (dest_ff > lo_ff))
      else $error("shift writes at or below the insertion point");

   a_place_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_PLACE) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not advance the count");

endmodule

// ===== hw/rtl/dense_rank_lookup.sv =====
// Dense rank lookup top level: input capture, sequencer, score memory, result register.
//
//   channel  direction  word            handshake
//   req_     in         req_word_type   req_valid / req_stall
//   rsp_     out        rsp_word_type   rsp_valid / rsp_stall
//
// One word at a time. Query: binary search, one search step per cycle through
// the single registered memory read port. Insert: the search plus a shift-up of
// the entries at and above the insertion point, paced by one memory read and
// one write per cycle.
// Reset clears the entry count and the control state; the table is not swept.
// A new word is taken while the previous result waits behind rsp_stall.
module dense_rank_lookup import drl_pkg::*; #(
   parameter int ENTRIES    = 1024,
   parameter int SCORE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEEP = (SCORE_BITS < FIELD_BITS) ? SCORE_BITS : FIELD_BITS;

   logic                  busy;
   logic                  req_take;
   logic [SCORE_BITS-1:0] req_key;
   logic                  res_valid;
   logic                  res_take;
   rsp_word_type          res_word;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [SCORE_BITS-1:0] wr_data, rd_data;

   assign req_stall = busy;
   assign req_take  = req_valid && !busy;
   assign req_key   = SCORE_BITS'(req_word.score[KEEP-1:0]);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign res_take  = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   drl_seq #(
      .ENTRIES    (ENTRIES),
      .SCORE_BITS (SCORE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req_cmd   (req_word.cmd),
      .req_key   (req_key),
      .busy      (busy),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_word  (res_word),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   drl_score_ram #(
      .ENTRIES    (ENTRIES),
      .SCORE_BITS (SCORE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== test/tb_dense_rank_lookup.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dense_rank_lookup: directed and random traffic.
module tb_dense_rank_lookup import drl_pkg::*; ();

   localparam int ENTRIES = 1024;
   localparam int SCORE_BITS = 32;
   localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_QUERY_HIGH = 2'd3;

   class rank_book;
      logic [SCORE_BITS-1:0] board[$];
      rsp_word_type owed[$];
      int errors = 0;
      int checked = 0;
      int n_ranked = 0;
      int n_inserted = 0;
      int n_duplicate = 0;
      int n_full = 0;
      int n_cleared = 0;
      int peak_rank = 0;

      function void note_word(req_word_type w);
         rsp_word_type e;
         int pos;
         int above;
         e = '0;
         if (w.cmd == CMD_CLEAR) begin
            board.delete();
            e.status = STATUS_CLEARED;
         end else if (w.cmd == CMD_INSERT) begin
            pos = 0;
            while (pos < board.size() && board[pos] < w.score) pos++;
            if (pos < board.size() && board[pos] == w.score) begin
               e.status = STATUS_DUPLICATE;
            end else if (board.size() >= ENTRIES) begin
               e.status = STATUS_FULL;
            end else begin
               board.insert(pos, w.score);
               e.status = STATUS_INSERTED;
            end
         end else begin
            above = 0;
            foreach (board[i]) if (board[i] > w.score) above++;
            e.rank = RANK_BITS'(above + 1);
            e.status = STATUS_RANKED;
         end
         owed.insert(owed.size(), e);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type e;
         if (owed.size() == 0) begin
            $error("unexpected result word: rank %0d status %0d", got.rank, got.status);
            errors++;
            return;
         end
         e = owed.pop_front();
         checked++;
         if (got.rank !== e.rank) begin
            $error("rank mismatch: expected %0d, actual %0d", e.rank, got.rank);
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
            errors++;
         end
         case (e.status)
            STATUS_RANKED: n_ranked++;
            STATUS_INSERTED: n_inserted++;
            STATUS_DUPLICATE: n_duplicate++;
            STATUS_FULL: n_full++;
            default: n_cleared++;
         endcase
         if (e.rank > peak_rank) peak_rank = e.rank;
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   rank_book book;
   int idle_pct = 0;
   int words_sent = 0;
   int stall_left = 0;

   dense_rank_lookup #(
      .ENTRIES(ENTRIES),
      .SCORE_BITS(SCORE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3) begin
            stall_left = $urandom_range(1, 11);
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_word(rsp_word);
   end

   task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [SCORE_BITS-1:0] score);
      req_word_type w;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      w.cmd = cmd;
      w.score = score;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      book.note_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [CMD_BITS-1:0] query_cmd();
      return $urandom_range(1) ? CMD_QUERY : CMD_QUERY_HIGH;
   endfunction

   function automatic logic [SCORE_BITS-1:0] pick_stored();
      if (book.board.size() == 0) return $urandom;
      return book.board[$urandom_range(book.board.size() - 1)];
   endfunction

   function automatic logic [SCORE_BITS-1:0] pick_score();
      logic [SCORE_BITS-1:0] nudge;
      nudge = $urandom_range(2);
      case ($urandom_range(4))
         0: return $urandom_range(0, 63);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         2: return pick_stored() + nudge - 32'd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      longint unsigned next_score;
      int r;
      book = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, extremes, duplicates, high command code
      send_word(CMD_QUERY, 32'h0000_0000);
      send_word(CMD_QUERY_HIGH, 32'hFFFF_FFFF);
      send_word(CMD_CLEAR, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h0000_0000);
      send_word(CMD_INSERT, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h0000_0000);
      send_word(CMD_INSERT, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h8000_0000);
      send_word(CMD_INSERT, 32'h7FFF_FFFF);
      send_word(CMD_QUERY, 32'h0000_0000);
      send_word(CMD_QUERY, 32'hFFFF_FFFF);
      send_word(CMD_QUERY, 32'h8000_0000);
      send_word(CMD_QUERY_HIGH, 32'h7FFF_FFFE);
      send_word(CMD_QUERY, 32'h5555_5555);
      send_word(CMD_INSERT, 32'hAAAA_AAAA);
      send_word(CMD_QUERY_HIGH, 32'hAAAA_AAAA);
      send_word(CMD_CLEAR, 32'h0000_0000);
      send_word(CMD_QUERY, 32'h8000_0000);
      send_word(CMD_INSERT, 32'h5555_5555);
      send_word(CMD_INSERT, 32'h0000_0001);
      send_word(CMD_QUERY, 32'h0000_0000);

      // random small tables
      while (words_sent < 60) begin
         idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
         send_word(CMD_CLEAR, $urandom);
         repeat ($urandom_range(1, 24)) begin
            r = $urandom_range(9);
            if (r < 6) send_word(CMD_INSERT, pick_score());
            else if (r < 8) send_word(CMD_INSERT, pick_stored());
            else send_word(query_cmd(), pick_score());
         end
         repeat ($urandom_range(2, 10)) send_word(query_cmd(), pick_score());
      end

      // fill to capacity, mostly ascending with some out-of-order inserts
      send_word(CMD_CLEAR, $urandom);
      next_score = $urandom_range(1, 4096);
      while (book.board.size() < ENTRIES) begin
         if (words_sent % 64 == 0) idle_pct = ($urandom_range(2) == 0) ? 0 : 20;
         r = $urandom_range(99);
         if (r < 92 && next_score < 64'hFFFF_0000) begin
            send_word(CMD_INSERT, next_score[SCORE_BITS-1:0]);
            next_score += $urandom_range(1, 1 << 21);
         end else if (r < 97) begin
            send_word(CMD_INSERT, $urandom);
         end else if (r < 98) begin
            send_word(CMD_INSERT, pick_stored());
         end else begin
            send_word(query_cmd(), pick_score());
         end
      end

      // full table, no idling from here
      idle_pct = 0;
      send_word(CMD_QUERY, 32'h0000_0000);
      send_word(CMD_QUERY_HIGH, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, 32'h0000_0000);
      send_word(CMD_INSERT, 32'hFFFF_FFFF);
      send_word(CMD_INSERT, pick_stored());
      repeat (12) begin
         r = $urandom_range(2);
         if (r == 0) send_word(CMD_INSERT, pick_score());
         else if (r == 1) send_word(CMD_INSERT, pick_stored());
         else send_word(query_cmd(), pick_score());
      end
      send_word(CMD_CLEAR, $urandom);
      send_word(CMD_QUERY, pick_score());
      send_word(CMD_INSERT, pick_score());
      send_word(CMD_QUERY_HIGH, 32'h0000_0000);

      @(negedge clock);
      req_valid <= 1'b0;
      while (book.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d words, checked %0d results: %0d ranked, %0d inserted, %0d cleared",
               words_sent, book.checked, book.n_ranked, book.n_inserted, book.n_cleared);
      $display("Duplicates %0d, full-table drops %0d, peak rank %0d",
               book.n_duplicate, book.n_full, book.peak_rank);
      if (book.errors == 0 && book.owed.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/drl_pkg.sv
hw/rtl/drl_score_ram.sv
hw/rtl/drl_seq.sv
hw/rtl/dense_rank_lookup.sv
test/tb_dense_rank_lookup.sv
